// ===== rtl/core/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DCSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define DCSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define DCSM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/dcsm_pkg.sv =====
`default_nettype none
package dcsm_pkg;

  localparam int SEM_COUNT = 16;
  localparam int DATA_W = 16;

  // operation codes
  localparam logic [3:0] KIND_READ_FLAGS  = 4'd0;
  localparam logic [3:0] KIND_SET         = 4'd1;
  localparam logic [3:0] KIND_CLEAR       = 4'd2;
  localparam logic [3:0] KIND_SEM_STATUS  = 4'd3;
  localparam logic [3:0] KIND_SEM_REQUEST = 4'd4;
  localparam logic [3:0] KIND_SEM_RELEASE = 4'd5;
  localparam logic [3:0] KIND_HOST_SET    = 4'd6;
  localparam logic [3:0] KIND_HOST_CLEAR  = 4'd7;
  localparam logic [3:0] KIND_TAKE_CLEAR  = 4'd8;

  // semaphore owner codes
  localparam logic [1:0] OWNER_FREE = 2'd0;
  localparam logic [1:0] OWNER_MCU  = 2'd1;
  localparam logic [1:0] OWNER_DSP  = 2'd2;

  // waiting marks
  localparam logic [1:0] WAIT_MCU = 2'b01;
  localparam logic [1:0] WAIT_DSP = 2'b10;

  typedef struct packed {
    logic [3:0]        kind;
    logic              side;
    logic [DATA_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] changed_bits;
    logic              changed_is_set;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/dcsm_ctrl.sv =====
`default_nettype none
module dcsm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output dcsm_pkg::cmd_t     cmd
);

  dcsm_pkg::state_t state, state_next;
  logic rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dcsm_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      dcsm_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = dcsm_pkg::ST_EXEC;
        end
      end
      dcsm_pkg::ST_EXEC: begin
        // commit only once the result register is free or being emptied
        if (!rsp_valid || rsp_ready) begin
          cmd.exec   = 1'b1;
          state_next = dcsm_pkg::ST_IDLE;
        end
      end
      default: state_next = dcsm_pkg::ST_IDLE;
    endcase
    if (cmd.exec) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/dcsm_datapath.sv =====
`default_nettype none
module dcsm_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire dcsm_pkg::cmd_t cmd,
  input  wire dcsm_pkg::req_t req,
  output dcsm_pkg::rsp_t      rsp
);

  dcsm_pkg::req_t cur;

  logic [dcsm_pkg::DATA_W-1:0] comm_flags, comm_flags_next;
  logic [dcsm_pkg::DATA_W-1:0] cleared_accum, cleared_accum_next;
  logic [1:0] sem_owner [dcsm_pkg::SEM_COUNT];
  logic [1:0] sem_owner_next [dcsm_pkg::SEM_COUNT];
  logic [1:0] sem_waiting [dcsm_pkg::SEM_COUNT];
  logic [1:0] sem_waiting_next [dcsm_pkg::SEM_COUNT];
  dcsm_pkg::rsp_t rsp_next;

  logic [1:0] me, other, my_wait, other_wait;
  logic [dcsm_pkg::DATA_W-1:0] status;
  logic [dcsm_pkg::DATA_W-1:0] d;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
    if (cmd.exec) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comm_flags    <= '0;
      cleared_accum <= '0;
      for (int i = 0; i < dcsm_pkg::SEM_COUNT; i++) begin
        sem_owner[i]   <= dcsm_pkg::OWNER_FREE;
        sem_waiting[i] <= '0;
      end
    end else if (cmd.exec) begin
      comm_flags    <= comm_flags_next;
      cleared_accum <= cleared_accum_next;
      for (int i = 0; i < dcsm_pkg::SEM_COUNT; i++) begin
        sem_owner[i]   <= sem_owner_next[i];
        sem_waiting[i] <= sem_waiting_next[i];
      end
    end
  end

  assign d          = cur.data_in;
  assign me         = cur.side ? dcsm_pkg::OWNER_DSP : dcsm_pkg::OWNER_MCU;
  assign other      = cur.side ? dcsm_pkg::OWNER_MCU : dcsm_pkg::OWNER_DSP;
  assign my_wait    = cur.side ? dcsm_pkg::WAIT_DSP : dcsm_pkg::WAIT_MCU;
  assign other_wait = cur.side ? dcsm_pkg::WAIT_MCU : dcsm_pkg::WAIT_DSP;

  // bits beyond the semaphore count read as not owned
  always_comb begin
    status = '1;
    for (int i = 0; i < dcsm_pkg::SEM_COUNT; i++) begin
      status[i] = (sem_owner[i] != me);
    end
  end

  always_comb begin
    comm_flags_next    = comm_flags;
    cleared_accum_next = cleared_accum;
    rsp_next           = '0;
    for (int i = 0; i < dcsm_pkg::SEM_COUNT; i++) begin
      sem_owner_next[i]   = sem_owner[i];
      sem_waiting_next[i] = sem_waiting[i];
    end
    case (cur.kind)
      dcsm_pkg::KIND_READ_FLAGS: rsp_next.read_data = comm_flags;
      dcsm_pkg::KIND_SET: begin
        rsp_next.changed_bits   = d & ~comm_flags;
        rsp_next.changed_is_set = 1'b1;
        comm_flags_next         = comm_flags | d;
      end
      dcsm_pkg::KIND_CLEAR: begin
        rsp_next.changed_bits = comm_flags & d;
        comm_flags_next       = comm_flags & ~d;
        cleared_accum_next    = cleared_accum | (comm_flags & d);
      end
      dcsm_pkg::KIND_SEM_STATUS: rsp_next.read_data = status;
      dcsm_pkg::KIND_SEM_REQUEST: begin
        for (int i = 0; i < dcsm_pkg::SEM_COUNT; i++) begin
          if (d[i]) begin
            if (sem_owner[i] == dcsm_pkg::OWNER_FREE) begin
              sem_owner_next[i] = me;
            end else if (sem_owner[i] != me) begin
              sem_waiting_next[i] = sem_waiting[i] | my_wait;
            end
          end
        end
      end
      dcsm_pkg::KIND_SEM_RELEASE: begin
        for (int i = 0; i < dcsm_pkg::SEM_COUNT; i++) begin
          if (d[i] && sem_owner[i] == me) begin
            // hand over straight to a waiting other side
            if ((sem_waiting[i] & other_wait) != 2'b00) begin
              sem_owner_next[i]   = other;
              sem_waiting_next[i] = sem_waiting[i] & ~other_wait;
            end else begin
              sem_owner_next[i] = dcsm_pkg::OWNER_FREE;
            end
          end
        end
      end
      dcsm_pkg::KIND_HOST_SET:   comm_flags_next = comm_flags | d;
      dcsm_pkg::KIND_HOST_CLEAR: comm_flags_next = comm_flags & ~d;
      dcsm_pkg::KIND_TAKE_CLEAR: begin
        rsp_next.read_data = cleared_accum;
        cleared_accum_next = '0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/dual_core_semaphore_mailbox.sv =====
// Mailbox flags and hardware semaphores shared by an MCU and a DSP. Every
// transaction on req gives exactly one transaction on rsp, in order. The
// controller captures a transaction in its idle state and applies it to the
// flags and all semaphores in parallel in its exec state; no new transaction
// is taken until the last one has been applied. A finished result sits
// in the rsp register while the next transaction is captured; the apply cycle
// waits only while that register is still full and not being taken.
`default_nettype none
module dual_core_semaphore_mailbox (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire dcsm_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output dcsm_pkg::rsp_t      rsp
);

  dcsm_pkg::cmd_t cmd;

  dcsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  dcsm_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule
`default_nettype wire

// ===== rtl/core/dcsm_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module dcsm_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire dcsm_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire dcsm_pkg::rsp_t rsp
);

  logic req_fire;
  assign req_fire = req_valid && req_ready;

  `DCSM_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !rsp_valid, "result valid after reset")
  `DCSM_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")
  `DCSM_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_fire, !req_ready, "transaction taken during apply cycle")
  `DCSM_ASSERT_NOW(a_set_no_read, clk, rst, rsp_valid && rsp.changed_is_set, rsp.read_data == '0, "set result carries read data")

endmodule

bind dual_core_semaphore_mailbox dcsm_checker u_dcsm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire
